@@ sv/bgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int BGC_TIME_BITS = 32;
	localparam int NOW_W         = 32;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_RELEASE = 3'd4;

	localparam logic [7:0]  DEBOUNCE_RST     = 8'd10;
	localparam logic [15:0] WINDOW_RST       = 16'd500;
	localparam logic [15:0] LONG_HOLD_RST    = 16'd5000;
	localparam logic [15:0] SHORT_MAX_RST    = 16'd1500;
	localparam logic [15:0] LONG_RELEASE_RST = 16'd4000;

	localparam logic [2:0] GEST_NONE   = 3'd0;
	localparam logic [2:0] GEST_SHORT  = 3'd1;
	localparam logic [2:0] GEST_LONG   = 3'd2;
	localparam logic [2:0] GEST_DOUBLE = 3'd3;
	localparam logic [2:0] GEST_TRIPLE = 3'd4;

	localparam logic [2:0] PRESS_MAX = 3'd7;

	typedef struct packed {
		logic [7:0]  settle_count;
		logic [15:0] window_ticks;
		logic [15:0] long_hold_ms;
		logic [15:0] short_max_ms;
		logic [15:0] long_release_ms;
	} bgc_cfg_t;

	typedef struct packed {
		logic [2:0] gesture;
		logic       press_held;
		logic [2:0] press_count;
	} bgc_result_t;

endpackage

@@ sv/bgc_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_tracker
// Gesture state: debounce, multi-press window, press timing and the
// reported gesture. Gives the post-update result of the item in flight.
// ----------------------------------------------------------------------------
module bgc_tracker import bgc_pkg::*; #(
	parameter int TIME_BITS = BGC_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 mode,
	input  logic                 pin_level,
	input  logic [TIME_BITS-1:0] now,
	input  bgc_cfg_t             cfg,
	output bgc_result_t          result
);

	logic                 last_level_q, last_level_d;
	logic [7:0]           debounce_left_q, debounce_left_d;
	logic [15:0]          window_left_q, window_left_d;
	logic                 held_q, held_d;
	logic                 long_seen_q, long_seen_d;
	logic [2:0]           count_q, count_d;
	logic [TIME_BITS-1:0] press_time_q, press_time_d;
	logic [2:0]           gesture_q, gesture_d;
	logic [TIME_BITS-1:0] elapsed;
	logic [2:0]           count_win;

	assign elapsed = now - press_time_q;

	always_comb begin
		last_level_d    = last_level_q;
		debounce_left_d = debounce_left_q;
		window_left_d   = window_left_q;
		held_d          = held_q;
		long_seen_d     = long_seen_q;
		count_d         = count_q;
		press_time_d    = press_time_q;
		gesture_d       = gesture_q;
		count_win       = count_q;
		if (mode) begin
			gesture_d = GEST_NONE;
		end else begin
			window_left_d = window_left_q - 16'd1;
			if (window_left_d == 16'd0) begin
				count_win     = 3'd0;
				window_left_d = cfg.window_ticks;
			end
			count_d = count_win;
			if (!pin_level) begin
				if (last_level_q) begin
					debounce_left_d = cfg.settle_count;
				end else if (debounce_left_q != 8'd0) begin
					debounce_left_d = debounce_left_q - 8'd1;
				end else if (!held_q) begin
					press_time_d = now;
					held_d       = 1'b1;
				end else if (elapsed > TIME_BITS'(cfg.long_hold_ms) && !long_seen_q) begin
					gesture_d   = GEST_LONG;
					long_seen_d = 1'b1;
					count_d     = 3'd0;
				end
				last_level_d = 1'b0;
			end else begin
				if (!last_level_q || !held_q) begin
					debounce_left_d = cfg.settle_count;
				end else if (debounce_left_q != 8'd0) begin
					debounce_left_d = debounce_left_q - 8'd1;
				end else begin
					window_left_d = cfg.window_ticks;
					count_d       = (count_win == PRESS_MAX) ? PRESS_MAX : count_win + 3'd1;
					press_time_d  = elapsed;
					held_d        = 1'b0;
					if (count_d > 3'd1 && elapsed < TIME_BITS'(cfg.short_max_ms)) begin
						if (count_d == 3'd2) begin
							gesture_d = GEST_DOUBLE;
						end else if (count_d == 3'd3) begin
							gesture_d = GEST_TRIPLE;
						end
					end else if (elapsed < TIME_BITS'(cfg.short_max_ms)) begin
						gesture_d = GEST_SHORT;
					end else if (elapsed > TIME_BITS'(cfg.long_release_ms) && !long_seen_q) begin
						count_d   = 3'd0;
						gesture_d = GEST_LONG;
					end
					long_seen_d = 1'b0;
				end
				last_level_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q    <= 1'b1;
			debounce_left_q <= DEBOUNCE_RST;
			window_left_q   <= WINDOW_RST;
			held_q          <= 1'b0;
			long_seen_q     <= 1'b0;
			count_q         <= 3'd0;
			press_time_q    <= '0;
			gesture_q       <= GEST_NONE;
		end else if (step) begin
			last_level_q    <= last_level_d;
			debounce_left_q <= debounce_left_d;
			window_left_q   <= window_left_d;
			held_q          <= held_d;
			long_seen_q     <= long_seen_d;
			count_q         <= count_d;
			press_time_q    <= press_time_d;
			gesture_q       <= gesture_d;
		end
	end

	assign result.gesture     = gesture_d;
	assign result.press_held  = held_d;
	assign result.press_count = count_d;

	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		gesture_q <= GEST_TRIPLE)
		else $error("gesture code out of range");

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode |=> gesture_q == GEST_NONE)
		else $error("acknowledge did not clear gesture");

	a_long_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		long_seen_q |-> held_q)
		else $error("long press flagged without a held press");

endmodule

@@ sv/button_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Debounced short, long, double and triple press detector on sampled pin
// beats with millisecond time stamps; acknowledge beats clear the gesture.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; one beat per cycle while
// out_stall does not hold the result register, with the bgc_tracker state
// updated on each accepted beat.
// Reset: arst_n clears both stages and loads the register defaults
// (debounce 10, window 500, long hold 5000, short max 1500, long release 4000).
// ----------------------------------------------------------------------------
module button_gesture_classifier import bgc_pkg::*; #(
	parameter int TIME_BITS = BGC_TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic                  pin_level,
	input  logic [NOW_W-1:0]      now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            gesture,
	output logic                  press_held,
	output logic [2:0]            press_count
);

	bgc_cfg_t             cfg_q;
	logic                 valid_s1;
	logic                 mode_s1;
	logic                 pin_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 out_free;
	logic                 step;
	bgc_result_t          result;
	bgc_result_t          result_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_count    <= DEBOUNCE_RST;
			cfg_q.window_ticks    <= WINDOW_RST;
			cfg_q.long_hold_ms    <= LONG_HOLD_RST;
			cfg_q.short_max_ms    <= SHORT_MAX_RST;
			cfg_q.long_release_ms <= LONG_RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:     cfg_q.settle_count    <= cfg_data[7:0];
				REG_WINDOW:       cfg_q.window_ticks    <= cfg_data;
				REG_LONG_HOLD:    cfg_q.long_hold_ms    <= cfg_data;
				REG_SHORT_MAX:    cfg_q.short_max_ms    <= cfg_data;
				REG_LONG_RELEASE: cfg_q.long_release_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// hold the input beat while the result register is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			pin_s1  <= pin_level;
			now_s1  <= TIME_BITS'(now_ms);
		end
	end

	bgc_tracker #(
		.TIME_BITS (TIME_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.mode      (mode_s1),
		.pin_level (pin_s1),
		.now       (now_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign gesture     = result_q.gesture;
	assign press_held  = result_q.press_held;
	assign press_count = result_q.press_count;

endmodule
